@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

@@ rtl/tga_pkg.sv @@
// types and constants of the tga rle pixel decoder
package tga_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [1:0] CSR_RLE_ENABLE      = 2'd1;
   localparam logic [1:0] CSR_EXPECTED_PIXELS = 2'd2;

   // register reset values
   localparam logic [2:0]  BPP_RESET      = 3'd3;
   localparam logic        RLE_RESET      = 1'b1;
   localparam logic [31:0] EXPECTED_RESET = 32'd0;

   // packet header count field
   localparam logic [6:0] COUNT_MASK = 7'h7f;

   // saturation limit of the decoded pixel total
   localparam logic [32:0] DECODED_MAX = {33{1'b1}};

   // result kind codes
   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // one queue entry: up to a pixel result followed by a status result
   typedef struct packed {
      logic       pix_valid;
      logic [7:0] raw3;
      logic [7:0] raw2;
      logic [7:0] raw1;
      logic [7:0] raw0;
      logic [1:0] bpp_m1;
      logic [7:0] repeat_cnt;
      logic       stat_valid;
      logic       size_error;
   } tga_entry_type;

endpackage

@@ rtl/tga_front.sv @@
// front end: byte acceptance, packet parsing and pixel assembly
module tga_front import tga_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_data_byte,
   input  logic          req_last_byte,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_wdata,
   input  logic          q_full,
   output logic          q_push,
   output tga_entry_type q_entry
);

   logic [2:0]  bpp_ff, bpp_in;
   logic        rle_ff, rle_in;
   logic [31:0] expected_ff, expected_in;
   logic        expect_header_ff, expect_header_in;
   logic        run_packet_ff, run_packet_in;
   logic [7:0]  left_ff, left_in;
   logic [1:0]  bip_ff, bip_in;
   logic [7:0]  pixel_bytes_ff [3];
   logic [7:0]  pixel_bytes_in [3];
   logic [32:0] decoded_ff, decoded_in;

   logic        accept;
   logic        is_header;
   logic        complete;
   logic [1:0]  bpp_m1;
   logic [7:0]  raw [4];
   logic [7:0]  rep;
   logic [33:0] sum;
   logic        unfinished;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;

   // effective pixel size minus one: zero acts as one, above four as four
   always_comb begin
      if (bpp_ff == 3'd0) begin
         bpp_m1 = 2'd0;
      end else if (bpp_ff > 3'd4) begin
         bpp_m1 = 2'd3;
      end else begin
         bpp_m1 = 2'(bpp_ff - 3'd1);
      end
   end

   always_comb begin
      bpp_in           = bpp_ff;
      rle_in           = rle_ff;
      expected_in      = expected_ff;
      expect_header_in = expect_header_ff;
      run_packet_in    = run_packet_ff;
      left_in          = left_ff;
      bip_in           = bip_ff;
      pixel_bytes_in   = pixel_bytes_ff;
      decoded_in       = decoded_ff;
      q_push           = 1'b0;
      q_entry          = '0;
      unfinished       = 1'b0;

      is_header = rle_ff && expect_header_ff;
      complete  = bip_ff >= bpp_m1;

      for (int i = 0; i < 3; i++) begin
         raw[i] = (i < int'(bpp_m1)) ? pixel_bytes_ff[i] : 8'd0;
      end
      raw[3] = 8'd0;
      raw[bpp_m1] = req_data_byte;

      rep = 8'd1;
      if (rle_ff && run_packet_ff && (left_ff != 8'd0)) begin
         rep = left_ff;
      end
      sum = {1'b0, decoded_ff} + 34'(rep);

      if (csr_wr_en) begin
         case (csr_index)
            CSR_BYTES_PER_PIXEL: bpp_in = csr_wdata[2:0];
            CSR_RLE_ENABLE:      rle_in = csr_wdata[0];
            CSR_EXPECTED_PIXELS: expected_in = csr_wdata;
            default: ;
         endcase
      end

      if (accept) begin
         if (is_header) begin
            run_packet_in    = req_data_byte[7];
            left_in          = {1'b0, req_data_byte[6:0] & COUNT_MASK} + 8'd1;
            expect_header_in = 1'b0;
            bip_in           = 2'd0;
         end else if (complete) begin
            if (rle_ff) begin
               if (run_packet_ff) begin
                  left_in = 8'd0;
               end else if (left_ff != 8'd0) begin
                  left_in = left_ff - 8'd1;
               end
               if (left_in == 8'd0) begin
                  expect_header_in = 1'b1;
               end
            end
            decoded_in = sum[33] ? DECODED_MAX : sum[32:0];
            bip_in     = 2'd0;
            q_entry.pix_valid  = 1'b1;
            q_entry.raw0       = raw[0];
            q_entry.raw1       = raw[1];
            q_entry.raw2       = raw[2];
            q_entry.raw3       = raw[3];
            q_entry.bpp_m1     = bpp_m1;
            q_entry.repeat_cnt = rep;
         end else begin
            if (bip_ff != 2'd3) begin
               pixel_bytes_in[bip_ff] = req_data_byte;
            end
            bip_in = bip_ff + 2'd1;
         end

         if (req_last_byte) begin
            unfinished = (bip_in != 2'd0) || (rle_ff && !expect_header_in);
            q_entry.stat_valid = 1'b1;
            q_entry.size_error = unfinished || (decoded_in != {1'b0, expected_ff});
            // stream state back to its start for the next image
            expect_header_in = 1'b1;
            run_packet_in    = 1'b0;
            left_in          = 8'd0;
            bip_in           = 2'd0;
            decoded_in       = '0;
         end

         q_push = q_entry.pix_valid || q_entry.stat_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff           <= BPP_RESET;
         rle_ff           <= RLE_RESET;
         expected_ff      <= EXPECTED_RESET;
         expect_header_ff <= 1'b1;
         run_packet_ff    <= 1'b0;
         left_ff          <= 8'd0;
         bip_ff           <= 2'd0;
         decoded_ff       <= '0;
      end else begin
         bpp_ff           <= bpp_in;
         rle_ff           <= rle_in;
         expected_ff      <= expected_in;
         expect_header_ff <= expect_header_in;
         run_packet_ff    <= run_packet_in;
         left_ff          <= left_in;
         bip_ff           <= bip_in;
         decoded_ff       <= decoded_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_bytes_ff <= pixel_bytes_in;
   end

endmodule

@@ rtl/tga_queue.sv @@
// short queue of decoded entries between front and back end
module tga_queue import tga_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  tga_entry_type push_entry,
   input  logic          pop,
   output tga_entry_type head_entry,
   output logic          full,
   output logic          empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   tga_entry_type    entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = count_ff == FULL_CNT;
   assign empty      = count_ff == '0;
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/tga_back.sv @@
// back end: channel ordering and result sequencing into the output register
module tga_back import tga_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  tga_entry_type head_entry,
   input  logic          q_empty,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_kind,
   output logic [7:0]    rsp_chan0,
   output logic [7:0]    rsp_chan1,
   output logic [7:0]    rsp_chan2,
   output logic [7:0]    rsp_chan3,
   output logic [7:0]    rsp_repeat_res,
   output logic          rsp_size_error
);

   logic       valid_ff, valid_in;
   logic       pix_done_ff, pix_done_in;
   logic       kind_ff, kind_in;
   logic [7:0] chan0_ff, chan0_in;
   logic [7:0] chan1_ff, chan1_in;
   logic [7:0] chan2_ff, chan2_in;
   logic [7:0] chan3_ff, chan3_in;
   logic [7:0] repeat_ff, repeat_in;
   logic       error_ff, error_in;

   logic       load;
   logic       take_pixel;

   assign load       = !valid_ff || rsp_ready;
   assign take_pixel = head_entry.pix_valid && !pix_done_ff;

   always_comb begin
      valid_in    = valid_ff;
      pix_done_in = pix_done_ff;
      kind_in     = kind_ff;
      chan0_in    = chan0_ff;
      chan1_in    = chan1_ff;
      chan2_in    = chan2_ff;
      chan3_in    = chan3_ff;
      repeat_in   = repeat_ff;
      error_in    = error_ff;
      q_pop       = 1'b0;

      if (load) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            if (take_pixel) begin
               kind_in   = KIND_PIXEL;
               repeat_in = head_entry.repeat_cnt;
               error_in  = 1'b0;
               // three and four byte pixels arrive blue first
               if (head_entry.bpp_m1 >= 2'd2) begin
                  chan0_in = head_entry.raw2;
                  chan1_in = head_entry.raw1;
                  chan2_in = head_entry.raw0;
               end else begin
                  chan0_in = head_entry.raw0;
                  chan1_in = head_entry.raw1;
                  chan2_in = head_entry.raw2;
               end
               chan3_in = head_entry.raw3;
               if (head_entry.stat_valid) begin
                  pix_done_in = 1'b1;
               end else begin
                  q_pop = 1'b1;
               end
            end else begin
               kind_in     = KIND_STATUS;
               chan0_in    = 8'd0;
               chan1_in    = 8'd0;
               chan2_in    = 8'd0;
               chan3_in    = 8'd0;
               repeat_in   = 8'd0;
               error_in    = head_entry.size_error;
               pix_done_in = 1'b0;
               q_pop       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         pix_done_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         pix_done_ff <= pix_done_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      chan0_ff  <= chan0_in;
      chan1_ff  <= chan1_in;
      chan2_ff  <= chan2_in;
      chan3_ff  <= chan3_in;
      repeat_ff <= repeat_in;
      error_ff  <= error_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_chan0      = chan0_ff;
   assign rsp_chan1      = chan1_ff;
   assign rsp_chan2      = chan2_ff;
   assign rsp_chan3      = chan3_ff;
   assign rsp_repeat_res = repeat_ff;
   assign rsp_size_error = error_ff;

endmodule

@@ rtl/tga_rle_pixel_decoder_core.sv @@
// top level of the tga rle pixel decoder
//
// usage
// - req channel: one word is one byte of the image data field, req_last_byte
//   marks the final byte; header fields come in through the csr write port
//   (pixel size, rle mode, expected pixel count), written while idle
// - rsp channel: pixel words (kind pixel) carry the channels in rgb(a) order
//   and a repeat count; a run packet gives one word with its full count
// - the byte flagged last also gives a status word with size_error set when
//   the pixel total differs from the expected count or a packet or pixel is
//   left unfinished; a pixel word, if any, comes first
// - a result word passes through the entry queue and then the output register
// - throughput: one byte per cycle unless the queue is full; a byte giving
//   a pixel and a status yields two words, absorbed by the queue (QUEUE_DEPTH)
// - a stalled rsp side fills the queue, then req_ready drops; bytes that give
//   no result (packet headers, partial pixels) never occupy the queue
// - reset: registers return to 3 bytes per pixel, rle on, expected count 0,
//   the stream waits for a packet header and the queue is emptied
// - after each status word the stream state starts over for the next image
`include "assert_macros.svh"

module tga_rle_pixel_decoder_core import tga_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_chan0,
   output logic [7:0]  rsp_chan1,
   output logic [7:0]  rsp_chan2,
   output logic [7:0]  rsp_chan3,
   output logic [7:0]  rsp_repeat_res,
   output logic        rsp_size_error,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   tga_entry_type push_entry;
   tga_entry_type head_entry;
   logic          q_push;
   logic          q_pop;
   logic          q_full;
   logic          q_empty;

   // parsing and pixel assembly, one byte per cycle while the queue is not full
   tga_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   // decouples byte intake from result delivery
   tga_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   // channel swap and pixel-then-status sequencing
   tga_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (head_entry),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_chan0      (rsp_chan0),
      .rsp_chan1      (rsp_chan1),
      .rsp_chan2      (rsp_chan2),
      .rsp_chan3      (rsp_chan3),
      .rsp_repeat_res (rsp_repeat_res),
      .rsp_size_error (rsp_size_error)
   );

   // no entry is dropped into a full queue
   `ASSERT_NEVER(a_no_overflow, q_push && q_full, "push into full queue")
   // the back end never pops an empty queue
   `ASSERT_NEVER(a_no_underflow, q_pop && q_empty, "pop from empty queue")
   // status words carry no repeat count
   `ASSERT_CLK(a_status_zero, (rsp_valid && (rsp_kind == KIND_STATUS)) |-> (rsp_repeat_res == 8'd0), "status word with repeat count")
   // pixel words repeat at least once and carry no error
   `ASSERT_CLK(a_pixel_ok, (rsp_valid && (rsp_kind == KIND_PIXEL)) |-> ((rsp_repeat_res != 8'd0) && !rsp_size_error), "malformed pixel word")

endmodule
